// File: rtl/slom_pkg.sv
package slom_pkg;

  localparam int unsigned CAPACITY_DEF   = 1024;
  localparam int unsigned LEVELS_DEF     = 16;
  localparam int unsigned KEY_BITS_DEF   = 32;
  localparam int unsigned VALUE_BITS_DEF = 32;

  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_SEARCH = 2'd1;
  localparam logic [1:0] OP_DELETE = 2'd2;

  localparam logic [1:0] STAT_OK       = 2'd0;
  localparam logic [1:0] STAT_NOTFOUND = 2'd1;
  localparam logic [1:0] STAT_FULL     = 2'd2;

  localparam logic [1:0] REG_LEVEL_LIMIT = 2'd0;
  localparam logic [1:0] REG_RNG_SEED    = 2'd1;
  localparam logic [1:0] REG_KEY_SIGNED  = 2'd2;

  localparam logic [4:0]  LIMIT_RST = 5'd16;
  localparam logic [31:0] SEED_RST  = 32'd1;

  typedef enum logic [16:0] {
    S_IDLE   = 17'h00001,
    S_LINK   = 17'h00002,
    S_LWAIT  = 17'h00004,
    S_CHK    = 17'h00008,
    S_KEY    = 17'h00010,
    S_DECIDE = 17'h00020,
    S_VAL    = 17'h00040,
    S_POP    = 17'h00080,
    S_LRD    = 17'h00100,
    S_LW1    = 17'h00200,
    S_LW2    = 17'h00400,
    S_DRD    = 17'h00800,
    S_DCHK   = 17'h01000,
    S_DW     = 17'h02000,
    S_PUSH   = 17'h04000,
    S_LOWER  = 17'h08000,
    S_FIN    = 17'h10000
  } state_t;

  function automatic logic [31:0] xorshift32(input logic [31:0] s);
    logic [31:0] x;
    x = s;
    x = x ^ (x << 13);
    x = x ^ (x >> 17);
    x = x ^ (x << 5);
    if (x == 32'd0) x = 32'd1;
    return x;
  endfunction

  function automatic logic [4:0] tz32(input logic [31:0] x);
    logic [4:0] r;
    r = 5'd0;
    for (int i = 31; i >= 0; i--) begin
      if (x[i]) r = 5'(i);
    end
    return r;
  endfunction

endpackage

// File: rtl/slom_ram.sv
module slom_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// File: rtl/skip_list_ordered_map.sv
// Operation: walks the search path node by node from the top level down, then
//   links the new node level by level on insert, or unlinks the found node
//   level by level and lowers empty top levels on delete.
// Throughput: one operation at a time; the next is accepted once the result is
//   in the output register. The pace is set by the link memory's one read port.
// Reset: empty map, all nodes free, level generator loaded with the seed.
module skip_list_ordered_map #(
  parameter int unsigned CAPACITY   = slom_pkg::CAPACITY_DEF,
  parameter int unsigned LEVELS     = slom_pkg::LEVELS_DEF,
  parameter int unsigned KEY_BITS   = slom_pkg::KEY_BITS_DEF,
  parameter int unsigned VALUE_BITS = slom_pkg::VALUE_BITS_DEF,
  localparam int unsigned CNT_W = $clog2(CAPACITY + 1)
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [3:0]            paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [1:0]            in_op,
  input  logic [KEY_BITS-1:0]   in_key,
  input  logic [VALUE_BITS-1:0] in_value,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [1:0]            out_status,
  output logic                  out_found,
  output logic [VALUE_BITS-1:0] out_value_out,
  output logic [CNT_W-1:0]      out_entry_count
);

  import slom_pkg::*;

  localparam int unsigned NODE_W = $clog2(CAPACITY);
  localparam int unsigned LINK_W = CNT_W;
  localparam int unsigned LVL_W  = (LEVELS > 1) ? $clog2(LEVELS) : 1;
  localparam int unsigned LA_W   = $clog2(CAPACITY * LEVELS);
  localparam logic [LINK_W-1:0] NIL = LINK_W'(CAPACITY);

  state_t                state_r;
  logic [1:0]            op_r;
  logic [KEY_BITS-1:0]   key_r;
  logic [VALUE_BITS-1:0] val_r;
  logic [LINK_W-1:0]     cur_r;
  logic [LINK_W-1:0]     nx_r;
  logic [NODE_W-1:0]     n_r;
  logic [LVL_W-1:0]      lv_r;
  logic [LVL_W-1:0]      i_r;
  logic [LVL_W-1:0]      h_r;
  logic [LVL_W-1:0]      top_r;
  logic                  found_r;
  logic [1:0]            status_r;
  logic [VALUE_BITS-1:0] vout_r;
  logic [CNT_W-1:0]      count_r;
  logic [CNT_W-1:0]      free_top_r;
  logic [CNT_W-1:0]      lwm_r;
  logic [31:0]           rng_r;
  logic [4:0]            limit_r;
  logic [31:0]           seed_r;
  logic                  ksig_r;
  logic [LINK_W-1:0]     head_r [LEVELS];
  logic [LINK_W-1:0]     pred_r [LEVELS];

  logic                  out_valid_r;
  logic [1:0]            out_status_r;
  logic                  out_found_r;
  logic [VALUE_BITS-1:0] out_value_r;
  logic [CNT_W-1:0]      out_count_r;

  logic                  link_we;
  logic [LA_W-1:0]       link_waddr;
  logic [LINK_W-1:0]     link_wdata;
  logic [LA_W-1:0]       link_raddr;
  logic [LINK_W-1:0]     link_rd;
  logic                  key_we;
  logic [KEY_BITS-1:0]   key_rd;
  logic                  val_we;
  logic [NODE_W-1:0]     val_waddr;
  logic [VALUE_BITS-1:0] val_rd;
  logic                  free_we;
  logic [NODE_W-1:0]     free_rd;

  logic                  cfg_wr;
  logic                  in_acc;
  logic [LINK_W-1:0]     pred_cur;
  logic                  pred_head;
  logic [CNT_W-1:0]      pop_idx;
  logic [NODE_W-1:0]     node_c;
  logic [5:0]            lim_c;
  logic [5:0]            tz_c;
  logic [LVL_W-1:0]      h_c;
  logic                  key_lt;
  logic [KEY_BITS-1:0]   sflip;

  function automatic logic [LA_W-1:0] la(input logic [NODE_W-1:0] nd,
                                         input logic [LVL_W-1:0] l);
    return LA_W'(nd) * LA_W'(LEVELS) + LA_W'(l);
  endfunction

  assign cfg_wr    = psel & penable & pwrite & pready;
  assign pready    = 1'b1;
  assign in_stall  = (state_r != S_IDLE);
  assign in_acc    = in_valid & ~in_stall;
  assign pred_cur  = pred_r[i_r];
  assign pred_head = (pred_cur == NIL);
  assign pop_idx   = free_top_r - CNT_W'(1);
  assign node_c    = (pop_idx < lwm_r)
                     ? (NODE_W'(CAPACITY - 1) - pop_idx[NODE_W-1:0]) : free_rd;
  assign sflip     = {ksig_r, {(KEY_BITS-1){1'b0}}};
  assign key_lt    = (key_rd ^ sflip) < (key_r ^ sflip);

  always_comb begin
    if (limit_r == 5'd0) lim_c = 6'd0;
    else if (6'(limit_r) > 6'(LEVELS)) lim_c = 6'(LEVELS - 1);
    else lim_c = 6'(limit_r) - 6'd1;
    tz_c = 6'(tz32(rng_r));
    h_c  = (tz_c > lim_c) ? LVL_W'(lim_c) : LVL_W'(tz_c);
  end

  always_comb begin
    case (paddr[3:2])
      REG_LEVEL_LIMIT: prdata = {27'd0, limit_r};
      REG_RNG_SEED:    prdata = seed_r;
      REG_KEY_SIGNED:  prdata = {31'd0, ksig_r};
      default:         prdata = 32'd0;
    endcase
  end

  always_comb begin
    link_we    = 1'b0;
    link_waddr = la(n_r, i_r);
    link_wdata = link_rd;
    link_raddr = la(pred_cur[NODE_W-1:0], i_r);
    case (state_r)
      S_LINK:  link_raddr = la(cur_r[NODE_W-1:0], lv_r);
      S_DCHK:  link_raddr = la(n_r, i_r);
      S_LW1: begin
        link_we    = 1'b1;
        link_wdata = pred_head ? head_r[i_r] : link_rd;
      end
      S_LW2: begin
        link_we    = ~pred_head;
        link_waddr = la(pred_cur[NODE_W-1:0], i_r);
        link_wdata = LINK_W'(n_r);
      end
      S_DW: begin
        link_we    = ~pred_head;
        link_waddr = la(pred_cur[NODE_W-1:0], i_r);
      end
      default: ;
    endcase
  end

  assign key_we    = (state_r == S_POP);
  assign val_we    = (state_r == S_POP) ||
                     (state_r == S_DECIDE && op_r == OP_INSERT && found_r);
  assign val_waddr = (state_r == S_POP) ? node_c : n_r;
  assign free_we   = (state_r == S_PUSH) && (free_top_r < CNT_W'(CAPACITY));

  slom_ram #(.WIDTH(LINK_W), .DEPTH(CAPACITY * LEVELS)) u_link (
    .clk(clk), .we(link_we), .waddr(link_waddr), .wdata(link_wdata),
    .raddr(link_raddr), .rdata(link_rd)
  );

  slom_ram #(.WIDTH(KEY_BITS), .DEPTH(CAPACITY)) u_key (
    .clk(clk), .we(key_we), .waddr(node_c), .wdata(key_r),
    .raddr(nx_r[NODE_W-1:0]), .rdata(key_rd)
  );

  slom_ram #(.WIDTH(VALUE_BITS), .DEPTH(CAPACITY)) u_val (
    .clk(clk), .we(val_we), .waddr(val_waddr), .wdata(val_r),
    .raddr(n_r), .rdata(val_rd)
  );

  slom_ram #(.WIDTH(NODE_W), .DEPTH(CAPACITY)) u_free (
    .clk(clk), .we(free_we), .waddr(free_top_r[NODE_W-1:0]), .wdata(n_r),
    .raddr(pop_idx[NODE_W-1:0]), .rdata(free_rd)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      top_r       <= '0;
      count_r     <= '0;
      free_top_r  <= CNT_W'(CAPACITY);
      lwm_r       <= CNT_W'(CAPACITY);
      rng_r       <= SEED_RST;
      seed_r      <= SEED_RST;
      limit_r     <= LIMIT_RST;
      ksig_r      <= 1'b0;
      out_valid_r <= 1'b0;
      for (int k = 0; k < LEVELS; k++) head_r[k] <= NIL;
    end else begin
      if (cfg_wr) begin
        case (paddr[3:2])
          REG_LEVEL_LIMIT: limit_r <= pwdata[4:0];
          REG_RNG_SEED: begin
            seed_r <= pwdata;
            rng_r  <= pwdata;
          end
          REG_KEY_SIGNED:  ksig_r <= pwdata[0];
          default: ;
        endcase
      end
      if (out_valid_r && !out_stall && state_r != S_FIN) out_valid_r <= 1'b0;

      case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            op_r     <= in_op;
            key_r    <= in_key;
            val_r    <= in_value;
            cur_r    <= NIL;
            lv_r     <= top_r;
            found_r  <= 1'b0;
            status_r <= STAT_OK;
            vout_r   <= '0;
            for (int k = 0; k < LEVELS; k++) pred_r[k] <= NIL;
            state_r  <= (in_op == OP_INSERT || in_op == OP_SEARCH ||
                         in_op == OP_DELETE) ? S_LINK : S_FIN;
          end
        end
        S_LINK: begin
          if (cur_r == NIL) begin
            nx_r    <= head_r[lv_r];
            state_r <= S_CHK;
          end else begin
            state_r <= S_LWAIT;
          end
        end
        S_LWAIT: begin
          nx_r    <= link_rd;
          state_r <= S_CHK;
        end
        S_CHK: begin
          if (nx_r == NIL) begin
            pred_r[lv_r] <= cur_r;
            if (lv_r == '0) state_r <= S_DECIDE;
            else begin
              lv_r    <= lv_r - LVL_W'(1);
              state_r <= S_LINK;
            end
          end else begin
            state_r <= S_KEY;
          end
        end
        S_KEY: begin
          if (key_lt) begin
            cur_r   <= nx_r;
            state_r <= S_LINK;
          end else begin
            pred_r[lv_r] <= cur_r;
            if (lv_r == '0) begin
              n_r     <= nx_r[NODE_W-1:0];
              found_r <= (key_rd == key_r);
              state_r <= S_DECIDE;
            end else begin
              lv_r    <= lv_r - LVL_W'(1);
              state_r <= S_LINK;
            end
          end
        end
        S_DECIDE: begin
          case (op_r)
            OP_SEARCH: state_r <= found_r ? S_VAL : S_FIN;
            OP_INSERT: begin
              if (found_r) state_r <= S_FIN;
              else if (free_top_r == '0) begin
                status_r <= STAT_FULL;
                state_r  <= S_FIN;
              end else begin
                rng_r   <= xorshift32(rng_r);
                state_r <= S_POP;
              end
            end
            default: begin
              if (found_r) begin
                i_r     <= '0;
                state_r <= S_DRD;
              end else begin
                status_r <= STAT_NOTFOUND;
                state_r  <= S_FIN;
              end
            end
          endcase
        end
        S_VAL: begin
          vout_r  <= val_rd;
          state_r <= S_FIN;
        end
        S_POP: begin
          n_r        <= node_c;
          free_top_r <= pop_idx;
          if (pop_idx < lwm_r) lwm_r <= pop_idx;
          count_r    <= count_r + CNT_W'(1);
          if (h_c > top_r) top_r <= h_c;
          h_r        <= h_c;
          i_r        <= '0;
          state_r    <= S_LRD;
        end
        S_LRD: state_r <= S_LW1;
        S_LW1: state_r <= S_LW2;
        S_LW2: begin
          if (pred_head) head_r[i_r] <= LINK_W'(n_r);
          if (i_r == h_r) state_r <= S_FIN;
          else begin
            i_r     <= i_r + LVL_W'(1);
            state_r <= S_LRD;
          end
        end
        S_DRD: state_r <= S_DCHK;
        S_DCHK: begin
          if ((pred_head ? head_r[i_r] : link_rd) != LINK_W'(n_r)) state_r <= S_PUSH;
          else state_r <= S_DW;
        end
        S_DW: begin
          if (pred_head) head_r[i_r] <= link_rd;
          if (i_r == top_r) state_r <= S_PUSH;
          else begin
            i_r     <= i_r + LVL_W'(1);
            state_r <= S_DRD;
          end
        end
        S_PUSH: begin
          if (free_top_r < CNT_W'(CAPACITY)) free_top_r <= free_top_r + CNT_W'(1);
          count_r <= count_r - CNT_W'(1);
          state_r <= S_LOWER;
        end
        S_LOWER: begin
          if (top_r != '0 && head_r[top_r] == NIL) top_r <= top_r - LVL_W'(1);
          else state_r <= S_FIN;
        end
        S_FIN: begin
          if (!out_valid_r || !out_stall) begin
            out_valid_r  <= 1'b1;
            out_status_r <= status_r;
            out_found_r  <= found_r;
            out_value_r  <= vout_r;
            out_count_r  <= count_r;
            state_r      <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_found       = out_found_r;
  assign out_value_out   = out_value_r;
  assign out_entry_count = out_count_r;

  a_pool_balance: assert property (@(posedge clk) disable iff (!rst_n)
    (32'(free_top_r) + 32'(count_r)) == 32'(CAPACITY))
    else $error("free count and entry count out of balance");

  a_lwm: assert property (@(posedge clk) disable iff (!rst_n)
    lwm_r <= free_top_r)
    else $error("free stack low-water mark above stack top");

  a_out_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_FIN))
    else $error("result loaded outside the finish step");

  a_walk_level: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_LINK) |-> (lv_r <= top_r))
    else $error("walk level above top level");

endmodule
